### rtl/core/assert_macros.svh
// assertion macros for the timeout queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DSTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSTQ_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSTQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSTQ_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/dstq_pkg.sv
// types and constants of the deadline sorted timeout queue
`default_nettype none
package dstq_pkg;

  localparam int DL_W  = 32;
  localparam int HD_W  = 16;
  localparam int OFF_W = 16;
  localparam int TPS_W = 7;
  localparam int MAX_OUT = 16;
  localparam int CNT_W = $clog2(MAX_OUT);

  localparam logic [TPS_W-1:0] TPS_RESET = 7'd50;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_INSTALL = 2'd1;
  localparam logic [1:0] KIND_REMOVE  = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [1:0] EV_ACK     = 2'd0;
  localparam logic [1:0] EV_EXPIRED = 2'd1;
  localparam logic [1:0] EV_FULL    = 2'd2;

  localparam logic [2:0] OP_HOLD    = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_MARK    = 3'd2;
  localparam logic [2:0] OP_COMPACT = 3'd3;
  localparam logic [2:0] OP_SHIFT   = 3'd4;

  typedef struct packed {
    logic            valid;
    logic [DL_W-1:0] deadline;
    logic [HD_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [DL_W-1:0] key;
    logic [HD_W-1:0] handle;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/dstq_cell.sv
// one slot of the sorted timeout chain
`default_nettype none
module dstq_cell import dstq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cmd_t   cmd,
  input  wire entry_t prev,
  input  wire logic   prev_flag,
  input  wire entry_t next,
  output logic        flag,
  output entry_t      ent
);

  logic            valid_r, valid_nxt;
  logic [DL_W-1:0] dl_r, dl_nxt;
  logic [HD_W-1:0] hd_r, hd_nxt;

  // slot at or behind the insert point
  assign flag = !valid_r || (dl_r >= cmd.key);
  assign ent  = '{valid: valid_r, deadline: dl_r, handle: hd_r};

  always_comb begin
    valid_nxt = valid_r;
    dl_nxt    = dl_r;
    hd_nxt    = hd_r;
    unique case (cmd.op)
      OP_INSERT: begin
        if (flag) begin
          if (prev_flag) begin
            valid_nxt = prev.valid;
            dl_nxt    = prev.deadline;
            hd_nxt    = prev.handle;
          end else begin
            valid_nxt = 1'b1;
            dl_nxt    = cmd.key;
            hd_nxt    = cmd.handle;
          end
        end
      end
      OP_MARK: begin
        if (valid_r && (hd_r == cmd.handle)) begin
          valid_nxt = 1'b0;
        end
      end
      OP_COMPACT: begin
        if (!valid_r && next.valid) begin
          valid_nxt = 1'b1;
          dl_nxt    = next.deadline;
          hd_nxt    = next.handle;
        end else if (valid_r && !prev.valid) begin
          valid_nxt = 1'b0;
        end
      end
      OP_SHIFT: begin
        valid_nxt = next.valid;
        dl_nxt    = next.deadline;
        hd_nxt    = next.handle;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    hd_r <= hd_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/deadline_sorted_timeout_queue.sv
// top level of the deadline sorted timeout queue
`default_nettype none
// Timeout queue of QUEUE_DEPTH entries held in a chain of slots sorted by
// deadline in seconds, earliest first. One transaction is taken at a time:
// an install, a remove, a tick or an unknown kind runs through ST_EXEC; a
// remove then compacts in ST_COMPACT, closing the holes left by the deleted
// entries one slot a cycle, and a tick that ends a second then drains in
// ST_DRAIN, one result per cycle from the chain head while the result
// register is free (at most 16 expiries). ST_EXEC also waits on a free
// result register, that is, on out_tready while a result is held.
// tuser carries the transaction kind on input and the event code on output.
module deadline_sorted_timeout_queue import dstq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [TPS_W-1:0] cfg_wdata,   // ticks_per_second
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,    // handle, offset_seconds
  input  wire logic [1:0]       in_tuser,    // kind
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [15:0]           out_tdata,   // expired_handle
  output logic [1:0]            out_tuser,   // event_res
  output logic                  out_tlast    // last
);

  `include "assert_macros.svh"

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_EXEC    = 2'd1;
  localparam logic [1:0] ST_COMPACT = 2'd2;
  localparam logic [1:0] ST_DRAIN   = 2'd3;

  localparam logic [QUEUE_DEPTH-1:0] ONE_D = QUEUE_DEPTH'(1);

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       kind_r;
  logic [HD_W-1:0]  hd_r;
  logic [DL_W-1:0]  when_r;
  logic [DL_W-1:0]  sec_r, sec_nxt;
  logic [TPS_W-1:0] tl_r, tl_nxt;
  logic [TPS_W-1:0] tps_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r;
  logic [1:0]       out_ev_r;
  logic [HD_W-1:0]  out_hd_r;
  logic             out_last_r;

  logic             emit, out_free;
  logic [1:0]       ev_sel;
  logic [HD_W-1:0]  hd_sel;
  logic             last_sel;

  cmd_t             cmd;
  entry_t           ent [QUEUE_DEPTH];
  logic             flag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld;
  logic             hole_gap;
  logic             head_exp, next_exp;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t prev_e, next_e;
      logic   prev_f;
      if (gi == 0) begin : g_first
        assign prev_e = '{valid: 1'b1, deadline: '0, handle: '0};
        assign prev_f = 1'b0;
      end else begin : g_mid
        assign prev_e = ent[gi-1];
        assign prev_f = flag[gi-1];
      end
      if (gi == QUEUE_DEPTH-1) begin : g_last
        assign next_e = '{valid: 1'b0, deadline: '0, handle: '0};
      end else begin : g_inner
        assign next_e = ent[gi+1];
      end
      dstq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .prev      (prev_e),
        .prev_flag (prev_f),
        .next      (next_e),
        .flag      (flag[gi]),
        .ent       (ent[gi])
      );
      assign vld[gi] = ent[gi].valid;
    end
  endgenerate

  assign hole_gap = |(~vld[QUEUE_DEPTH-2:0] & vld[QUEUE_DEPTH-1:1]);
  assign head_exp = ent[0].valid && (ent[0].deadline <= sec_r);
  assign next_exp = ent[1].valid && (ent[1].deadline <= sec_r);

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    sec_nxt    = sec_r;
    tl_nxt     = tl_r;
    cnt_nxt    = cnt_r;
    cmd.op     = OP_HOLD;
    cmd.key    = when_r;
    cmd.handle = hd_r;
    emit       = 1'b0;
    ev_sel     = EV_ACK;
    hd_sel     = '0;
    last_sel   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          case (kind_r)
            KIND_INSTALL: begin
              if (vld[QUEUE_DEPTH-1]) begin
                ev_sel = EV_FULL;
              end else begin
                cmd.op = OP_INSERT;
              end
            end
            KIND_REMOVE: begin
              cmd.op    = OP_MARK;
              state_nxt = ST_COMPACT;
            end
            KIND_TICK: begin
              if (tl_r <= 7'd1) begin
                tl_nxt    = (tps_r == '0) ? 7'd1 : tps_r;
                sec_nxt   = sec_r + 32'd1;
                cnt_nxt   = '0;
                emit      = 1'b0;
                state_nxt = ST_DRAIN;
              end else begin
                tl_nxt = tl_r - 7'd1;
              end
            end
            default: begin
              ev_sel = EV_ACK;
            end
          endcase
        end
      end
      ST_COMPACT: begin
        if (hole_gap) begin
          cmd.op = OP_COMPACT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (head_exp) begin
            ev_sel   = EV_EXPIRED;
            hd_sel   = ent[0].handle;
            last_sel = (cnt_r == CNT_W'(MAX_OUT - 1)) || !next_exp;
            cmd.op   = OP_SHIFT;
            cnt_nxt  = cnt_r + CNT_W'(1);
            if (last_sel) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      tl_r        <= TPS_RESET;
      tps_r       <= TPS_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
      tl_r    <= tl_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      hd_r   <= in_tdata[HD_W-1:0];
      when_r <= sec_r + {{(DL_W-OFF_W){1'b0}}, in_tdata[HD_W+OFF_W-1:HD_W]};
    end
    if (emit) begin
      out_ev_r   <= ev_sel;
      out_hd_r   <= hd_sel;
      out_last_r <= last_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = out_hd_r;
  assign out_tlast  = out_last_r;

  `DSTQ_ASSERT(a_packed_idle, clk, rst_n,
    (state_r == ST_IDLE) |-> (((vld + ONE_D) & vld) == '0),
    "queue not packed while idle")
  `DSTQ_ASSERT(a_full_hold, clk, rst_n,
    (state_r == ST_EXEC && kind_r == KIND_INSTALL && vld[QUEUE_DEPTH-1] && out_free)
      |=> $stable(vld),
    "full install changed the queue")
  `DSTQ_ASSERT(a_drain_shift, clk, rst_n,
    (state_r == ST_DRAIN && emit && ev_sel == EV_EXPIRED) |=> (vld == ($past(vld) >> 1)),
    "expiry did not pop the head")
  `DSTQ_ASSERT_NR(a_sec_step, clk,
    (rst_n && $past(rst_n) && (sec_r != $past(sec_r))) |-> (sec_r == $past(sec_r) + 32'd1),
    "seconds counter jumped")

endmodule
`default_nettype wire
